### rtl/core/assert_macros.svh
// assertion macros used by the queue top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define SPQ_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define SPQ_ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");
`else
`define SPQ_ASSERT(lbl, clk, rst, prop)
`define SPQ_ASSERT_NEVER(lbl, clk, rst, expr)
`endif

`endif

### rtl/core/spq_pkg.sv
// shared types and constants of the sorted priority queue
package spq_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int PRIO_W       = 32;
  localparam int DATA_W       = 32;
  localparam int STATUS_W     = 2;
  localparam int OCC_W        = 5;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [DATA_W-1:0] payload;
  } cell_data_t;

  typedef struct packed {
    logic              ins;
    logic              del;
    logic [PRIO_W-1:0] prio;
    logic [DATA_W-1:0] payload;
  } cell_ctrl_t;

endpackage

### rtl/core/spq_cell.sv
// one slot of the sorted chain: compares with the new entry and shifts
module spq_cell (
  input  logic               clk,
  input  spq_pkg::cell_ctrl_t ctrl,
  input  logic               occ,
  input  spq_pkg::cell_data_t left,
  input  logic               left_gt,
  input  spq_pkg::cell_data_t right,
  output spq_pkg::cell_data_t data,
  output logic               gt
);
  import spq_pkg::*;

  assign gt = occ && ($signed(data.prio) > $signed(ctrl.prio));

  always_ff @(posedge clk) begin
    if (ctrl.ins && (gt || !occ)) begin
      if (left_gt) begin
        data <= left;
      end else begin
        data.prio    <= ctrl.prio;
        data.payload <= ctrl.payload;
      end
    end else if (ctrl.del) begin
      data <= right;
    end
  end

endmodule

### rtl/core/stable_min_priority_queue.sv
// top level of the stable sorted-list min-priority queue
// Each start transfer is an insert or a delete-min and is always accepted;
// busy stays low, so a new item may follow in every cycle. The result appears
// on the cycle after the transfer, marked by done for exactly one cycle, and
// cannot be held off by the receiver. Entries sit in a chain of CAPACITY
// cells that all compare against the new priority at once; equal priorities
// leave in arrival order. An insert into a full queue is dropped (status 2),
// a delete on an empty queue returns 0 (status 1). occupancy carries the low
// five bits of the entry count.
`include "assert_macros.svh"

module stable_min_priority_queue #(
  parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic                               operation,
  input  logic signed [spq_pkg::PRIO_W-1:0]  priority_req,
  input  logic signed [spq_pkg::DATA_W-1:0]  payload,
  output logic                               done,
  output logic signed [spq_pkg::DATA_W-1:0]  removed_payload,
  output logic        [spq_pkg::STATUS_W-1:0] status,
  output logic        [spq_pkg::OCC_W-1:0]   occupancy
);
  import spq_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;
  logic                accept;
  logic                is_full;
  logic                is_empty;
  cell_ctrl_t          ctrl;
  cell_data_t          cell_q   [CAPACITY];
  logic [CAPACITY-1:0] cell_gt;
  logic [STATUS_W-1:0] status_next;

  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign is_full  = (count == CW'(CAPACITY));
  assign is_empty = (count == '0);

  always_comb begin
    ctrl.ins     = accept && (operation == OP_INSERT) && !is_full;
    ctrl.del     = accept && (operation == OP_DELETE) && !is_empty;
    ctrl.prio    = priority_req;
    ctrl.payload = payload;
    count_next   = count;
    status_next  = ST_OK;
    if (operation == OP_INSERT) begin
      if (is_full) begin
        status_next = ST_FULL;
      end else begin
        count_next = count + CW'(1);
      end
    end else begin
      if (is_empty) begin
        status_next = ST_EMPTY;
      end else begin
        count_next = count - CW'(1);
      end
    end
  end

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      cell_data_t left_d;
      cell_data_t right_d;
      logic       left_gt;
      if (i == 0) begin : g_head
        assign left_d  = '0;
        assign left_gt = 1'b0;
      end else begin : g_mid
        assign left_d  = cell_q[i-1];
        assign left_gt = cell_gt[i-1];
      end
      if (i == CAPACITY - 1) begin : g_tail
        assign right_d = cell_q[i];
      end else begin : g_body
        assign right_d = cell_q[i+1];
      end
      spq_cell u_cell (
        .clk     (clk),
        .ctrl    (ctrl),
        .occ     (count > CW'(i)),
        .left    (left_d),
        .left_gt (left_gt),
        .right   (right_d),
        .data    (cell_q[i]),
        .gt      (cell_gt[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= accept;
      if (accept) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status          <= status_next;
      occupancy       <= OCC_W'(count_next);
      removed_payload <= ctrl.del ? $signed(cell_q[0].payload) : '0;
    end
  end

  `SPQ_ASSERT(a_done_follows, clk, rst, (!rst && accept) |=> done)
  `SPQ_ASSERT(a_no_spurious, clk, rst, (!rst && !accept) |=> !done)
  `SPQ_ASSERT_NEVER(a_count_range, clk, rst, count > CW'(CAPACITY))
  `SPQ_ASSERT(a_full_status, clk, rst,
    (done && status == ST_FULL) |-> (occupancy == OCC_W'(CAPACITY)))
  `SPQ_ASSERT(a_empty_status, clk, rst,
    (done && status == ST_EMPTY) |-> (removed_payload == '0 && occupancy == '0))

endmodule

### tb/tb.sv
// self-checking testbench for the stable sorted-list min-priority queue
`timescale 1ns / 100ps

module tb;
  import spq_pkg::*;

  localparam int QCAP = CAPACITY_DEF;

  typedef struct {
    logic              op;
    logic [PRIO_W-1:0] prio;
    logic [DATA_W-1:0] data;
    bit                hold;
  } queue_cmd_t;

  typedef struct {
    logic [DATA_W-1:0]   removed;
    logic [STATUS_W-1:0] stat;
    logic [OCC_W-1:0]    occ;
  } queue_resp_t;

  typedef struct {
    logic signed [PRIO_W-1:0] prio;
    logic [DATA_W-1:0]        data;
  } stored_entry_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic operation;
  logic signed [PRIO_W-1:0] priority_req;
  logic signed [DATA_W-1:0] payload;
  logic done;
  logic signed [DATA_W-1:0] removed_payload;
  logic [STATUS_W-1:0] status;
  logic [OCC_W-1:0] occupancy;

  queue_cmd_t    pending_cmds[$];
  queue_resp_t   expected_resp[$];
  stored_entry_t sorted_entries[$];

  bit xfer_seen;
  int idle_left;
  int errors;
  int n_insert, n_delete, n_full_drop, n_empty_del, peak_count, n_checked;

  stable_min_priority_queue dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .operation(operation),
    .priority_req(priority_req),
    .payload(payload),
    .done(done),
    .removed_payload(removed_payload),
    .status(status),
    .occupancy(occupancy)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic queue_resp_t predict_response(logic op, logic signed [PRIO_W-1:0] prio,
                                                   logic [DATA_W-1:0] data);
    queue_resp_t r;
    stored_entry_t e;
    int pos;
    r.removed = '0;
    r.stat = ST_OK;
    if (op == OP_INSERT) begin
      n_insert++;
      if (sorted_entries.size() >= QCAP) begin
        r.stat = ST_FULL;
        n_full_drop++;
      end else begin
        pos = 0;
        while (pos < sorted_entries.size() && sorted_entries[pos].prio <= prio) pos++;
        e.prio = prio;
        e.data = data;
        sorted_entries.insert(pos, e);
      end
    end else begin
      n_delete++;
      if (sorted_entries.size() == 0) begin
        r.stat = ST_EMPTY;
        n_empty_del++;
      end else begin
        e = sorted_entries.pop_front();
        r.removed = e.data;
      end
    end
    if (sorted_entries.size() > peak_count) peak_count = sorted_entries.size();
    r.occ = OCC_W'(sorted_entries.size());
    return r;
  endfunction

  function automatic void push_cmd(logic op, logic [PRIO_W-1:0] prio, logic [DATA_W-1:0] data,
                                   bit hold);
    queue_cmd_t c;
    c.op = op;
    c.prio = prio;
    c.data = data;
    c.hold = hold;
    pending_cmds.push_back(c);
  endfunction

  // driver
  always @(negedge clk) begin
    queue_cmd_t nxt;
    if (rst) begin
      start <= 1'b0;
    end else if (!start || xfer_seen) begin
      if (idle_left > 0) begin
        idle_left--;
        start <= 1'b0;
      end else if (pending_cmds.size() == 0) begin
        start <= 1'b0;
      end else if (pending_cmds[0].hold && expected_resp.size() != 0) begin
        start <= 1'b0;
      end else begin
        nxt = pending_cmds.pop_front();
        operation <= nxt.op;
        priority_req <= nxt.prio;
        payload <= nxt.data;
        start <= 1'b1;
        if (pending_cmds.size() > 200 && $urandom_range(0, 3) == 0)
          idle_left = $urandom_range(1, 6);
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    queue_resp_t want;
    xfer_seen = 1'b0;
    if (!rst) begin
      if (start && !busy) begin
        xfer_seen = 1'b1;
        expected_resp.push_back(predict_response(operation, priority_req, payload));
      end
      if (done) begin
        if (expected_resp.size() == 0) begin
          $error("result transfer with no expectation pending");
          errors++;
        end else begin
          want = expected_resp.pop_front();
          n_checked++;
          if (removed_payload !== want.removed) begin
            $error("removed_payload: expected %0d, got %0d", $signed(want.removed),
                   removed_payload);
            errors++;
          end
          if (status !== want.stat) begin
            $error("status: expected %0d, got %0d", want.stat, status);
            errors++;
          end
          if (occupancy !== want.occ) begin
            $error("occupancy: expected %0d, got %0d", want.occ, occupancy);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    int ins_pct;
    int sel;
    int guard;
    logic [PRIO_W-1:0] p;

    rst = 1'b1;
    start = 1'b0;
    operation = OP_INSERT;
    priority_req = '0;
    payload = '0;
    idle_left = 0;
    errors = 0;

    // directed: delete on empty, extremes, ties, fill to full, dropped insert
    push_cmd(OP_DELETE, 32'h1234_5678, 32'hdead_beef, 1'b0);
    push_cmd(OP_INSERT, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
    push_cmd(OP_INSERT, 32'h8000_0000, 32'h8000_0000, 1'b0);
    push_cmd(OP_INSERT, 32'h0000_0000, 32'h0000_0000, 1'b0);
    push_cmd(OP_INSERT, 32'hffff_ffff, 32'hffff_ffff, 1'b0);
    push_cmd(OP_INSERT, 32'h0000_0001, 32'h0000_0011, 1'b0);
    push_cmd(OP_INSERT, 32'h0000_0005, 32'h0000_0a01, 1'b0);
    push_cmd(OP_INSERT, 32'h0000_0005, 32'h0000_0a02, 1'b0);
    push_cmd(OP_INSERT, 32'h0000_0005, 32'h0000_0a03, 1'b0);
    push_cmd(OP_INSERT, 32'h8000_0000, 32'h5555_5555, 1'b0);
    push_cmd(OP_INSERT, 32'h7fff_ffff, 32'haaaa_aaaa, 1'b0);
    push_cmd(OP_INSERT, 32'hffff_ffff, 32'h0f0f_0f0f, 1'b0);
    push_cmd(OP_INSERT, 32'h8000_0001, 32'hf0f0_f0f0, 1'b0);
    push_cmd(OP_INSERT, 32'h7fff_fffe, 32'h0000_0001, 1'b0);
    push_cmd(OP_INSERT, 32'h0000_0005, 32'h0000_0a04, 1'b0);
    push_cmd(OP_INSERT, 32'h0000_0000, 32'h1111_1111, 1'b0);
    push_cmd(OP_INSERT, 32'h0000_0002, 32'h2222_2222, 1'b0);
    push_cmd(OP_INSERT, 32'h8000_0000, 32'h3333_3333, 1'b0);
    for (int i = 0; i < 6; i++)
      push_cmd(OP_DELETE, $urandom, $urandom, 1'b0);

    // random: stretches biased toward filling, emptying or neither, many tied priorities
    for (int i = 0; i < 1500; i++) begin
      if (i % 50 == 0) begin
        sel = $urandom_range(0, 2);
        ins_pct = (sel == 0) ? 20 : (sel == 1) ? 50 : 80;
      end
      sel = $urandom_range(0, 9);
      if (sel <= 5) begin
        p = $urandom_range(0, 6);
        p = p - 3;
      end else if (sel <= 7) begin
        p = $urandom;
      end else if (sel == 8) begin
        p = 32'h7fff_ffff;
      end else begin
        p = 32'h8000_0000;
      end
      push_cmd(($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_DELETE, p, $urandom,
               (i % 500 == 0));
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_cmds.size() != 0 || start) @(posedge clk);
    guard = 0;
    while (expected_resp.size() != 0 && guard < 1000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
    if (expected_resp.size() != 0) begin
      $error("%0d expected results never arrived", expected_resp.size());
      errors++;
    end

    $display("covered %0d inserts (%0d dropped on full), %0d deletes (%0d on empty)",
             n_insert, n_full_drop, n_delete, n_empty_del);
    $display("checked %0d results, peak queue depth %0d of %0d", n_checked, peak_count, QCAP);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #400_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
